@@ hw/rtl/psmt_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet tracker.
`timescale 1ns / 1ps
`default_nettype none

package psmt_pkg;

  // Width of the screen limit registers.
  localparam int unsigned CfgW = 13;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 1;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 1'b1;

  // Reset values of the limits.
  localparam logic [CfgW-1:0] ScreenWidthRst  = 13'd1024;
  localparam logic [CfgW-1:0] ScreenHeightRst = 13'd768;

  // Reset cursor position before saturation to the coordinate range.
  localparam int unsigned CurXRst = 512;
  localparam int unsigned CurYRst = 384;

  // Header byte bit positions.
  localparam int unsigned HdrLeftBit   = 0;
  localparam int unsigned HdrRightBit  = 1;
  localparam int unsigned HdrMiddleBit = 2;
  localparam int unsigned HdrSyncBit   = 3;
  localparam int unsigned HdrXSignBit  = 4;
  localparam int unsigned HdrYSignBit  = 5;

  // Signed delta width after negation of the Y delta (-255..256).
  localparam int unsigned DeltaW = 10;

  // Byte position within a packet.
  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_e;

endpackage

`default_nettype wire

@@ hw/rtl/psmt_axis.sv @@
// One cursor axis: add a signed delta and clamp to the screen limit.
`timescale 1ns / 1ps
`default_nettype none

module psmt_axis #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0]           cur_i,
  input  wire logic signed [psmt_pkg::DeltaW-1:0] delta_i,
  input  wire logic [psmt_pkg::CfgW-1:0]       limit_i,
  output logic      [COORD_BITS-1:0]           next_o
);

  localparam int unsigned MaxW = (COORD_BITS > psmt_pkg::CfgW) ? COORD_BITS : psmt_pkg::CfgW;
  localparam int unsigned SW   = MaxW + 2;
  localparam logic [SW-1:0] CMax = SW'((64'd1 << COORD_BITS) - 64'd1);

  logic [psmt_pkg::CfgW-1:0] lim_m1;
  logic [SW-1:0]             lim_ext;
  logic [SW-1:0]             top;
  logic [SW-1:0]             sum;
  logic [SW-1:0]             sel;

  always_comb begin
    // a zero limit acts as one
    lim_m1  = (limit_i == '0) ? '0 : limit_i - psmt_pkg::CfgW'(1);
    lim_ext = {{(SW - psmt_pkg::CfgW){1'b0}}, lim_m1};
    top     = (lim_ext > CMax) ? CMax : lim_ext;
    sum     = {{(SW - COORD_BITS){1'b0}}, cur_i}
            + {{(SW - psmt_pkg::DeltaW){delta_i[psmt_pkg::DeltaW-1]}}, delta_i};
    if (sum[SW-1]) begin
      sel = '0;
    end else if (sum > top) begin
      sel = top;
    end else begin
      sel = sum;
    end
    next_o = sel[COORD_BITS-1:0];
  end

endmodule

`default_nettype wire

@@ hw/rtl/ps2_mouse_packet_tracker.sv @@
// Top level of the PS/2 mouse packet tracker.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one controller byte per
//   request with its aux flag. Bytes are gathered into 3-byte packets; while
//   waiting for a header, non-aux bytes and bytes without the sync bit are
//   dropped. The third byte of a packet yields one request on the output
//   channel (out_valid_o / out_ready_i): clamped cursor x/y and three buttons.
//   Order: an accepted request is first held in the input register, then
//   processed; a packet's result is registered in the result register.
//   Throughput: one byte per cycle. The input register and the result
//   register are decoupled; a byte is processed whenever the result register
//   is free or being drained in the same cycle.
//   Receiver stall: the result holds; one more byte is taken into the input
//   register, then in_ready_o drops until the result is taken.
//   Configuration: cfg_we_i writes cfg_wdata_i into the limit selected by
//   cfg_idx_i (0 width, 1 height); new limits apply to packets completed after the write.
//   Reset: asynchronous, active low; phase back to header, limits 1024x768,
//   cursor at 512,384 (saturated to the coordinate range), no results pending.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [psmt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [psmt_pkg::CfgW-1:0]     cfg_wdata_i,
  // byte input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic                          from_aux_i,
  // packet result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [COORD_BITS-1:0]              pos_x_o,
  output logic [COORD_BITS-1:0]              pos_y_o,
  output logic                               btn_left_o,
  output logic                               btn_right_o,
  output logic                               btn_middle_o
);

  localparam int unsigned CMaxI = (1 << COORD_BITS) - 1;
  localparam logic [COORD_BITS-1:0] RstX =
    COORD_BITS'((CMaxI < psmt_pkg::CurXRst) ? CMaxI : psmt_pkg::CurXRst);
  localparam logic [COORD_BITS-1:0] RstY =
    COORD_BITS'((CMaxI < psmt_pkg::CurYRst) ? CMaxI : psmt_pkg::CurYRst);

  // limit registers
  logic [psmt_pkg::CfgW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= psmt_pkg::ScreenWidthRst;
      height_q <= psmt_pkg::ScreenHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psmt_pkg::RegScreenWidth:  width_q  <= cfg_wdata_i;
        psmt_pkg::RegScreenHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_aux_q;
  logic       proc;

  // a held byte moves on when the result slot is free or draining
  assign proc       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
      in_aux_q  <= from_aux_i;
    end
  end

  // packet assembly
  psmt_pkg::phase_e         phase_q, phase_d;
  logic [7:0]               hdr_q, hdr_d;
  logic [7:0]               dx_q, dx_d;
  logic [COORD_BITS-1:0]    cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0]    cur_y_q, cur_y_d;
  logic                     pkt_done;

  logic signed [psmt_pkg::DeltaW-1:0] dx_ext, dy_neg;
  logic [COORD_BITS-1:0]    next_x, next_y;

  // 9-bit deltas; y is negated so screen-down is positive
  always_comb begin
    dx_ext = {hdr_q[psmt_pkg::HdrXSignBit], hdr_q[psmt_pkg::HdrXSignBit], dx_q};
    dy_neg = psmt_pkg::DeltaW'(0)
           - {hdr_q[psmt_pkg::HdrYSignBit], hdr_q[psmt_pkg::HdrYSignBit], in_byte_q};
  end

  psmt_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .cur_i   (cur_x_q),
    .delta_i (dx_ext),
    .limit_i (width_q),
    .next_o  (next_x)
  );

  psmt_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .cur_i   (cur_y_q),
    .delta_i (dy_neg),
    .limit_i (height_q),
    .next_o  (next_y)
  );

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    dx_d     = dx_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    pkt_done = 1'b0;
    if (proc) begin
      unique case (phase_q)
        psmt_pkg::PH_HEAD: begin
          // drop non-aux bytes and bytes out of sync
          if (in_aux_q && in_byte_q[psmt_pkg::HdrSyncBit]) begin
            hdr_d   = in_byte_q;
            phase_d = psmt_pkg::PH_DX;
          end
        end
        psmt_pkg::PH_DX: begin
          dx_d    = in_byte_q;
          phase_d = psmt_pkg::PH_DY;
        end
        psmt_pkg::PH_DY: begin
          cur_x_d  = next_x;
          cur_y_d  = next_y;
          pkt_done = 1'b1;
          phase_d  = psmt_pkg::PH_HEAD;
        end
        default: begin
          phase_d = psmt_pkg::PH_HEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= psmt_pkg::PH_HEAD;
      hdr_q   <= '0;
      dx_q    <= '0;
      cur_x_q <= RstX;
      cur_y_q <= RstY;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      dx_q    <= dx_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pkt_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_done) begin
      pos_x_o      <= next_x;
      pos_y_o      <= next_y;
      btn_left_o   <= hdr_q[psmt_pkg::HdrLeftBit];
      btn_right_o  <= hdr_q[psmt_pkg::HdrRightBit];
      btn_middle_o <= hdr_q[psmt_pkg::HdrMiddleBit];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/psmt_checker.sv @@
// Port-level checks for the PS/2 mouse packet tracker, with bind.
`timescale 1ns / 1ps
`default_nettype none

module psmt_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [psmt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [psmt_pkg::CfgW-1:0]     cfg_wdata_i,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [7:0]                    rx_byte_i,
  input wire logic                          from_aux_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [COORD_BITS-1:0]         pos_x_o,
  input wire logic [COORD_BITS-1:0]         pos_y_o,
  input wire logic                          btn_left_o,
  input wire logic                          btn_right_o,
  input wire logic                          btn_middle_o
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o)
      && $stable(btn_left_o) && $stable(btn_right_o) && $stable(btn_middle_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // a fresh result follows an accepted byte request
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without input");

  // no result during reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind ps2_mouse_packet_tracker psmt_checker #(.COORD_BITS(COORD_BITS)) u_psmt_checker (.*);

`default_nettype wire
